[rtl/core/rgcd_pkg.sv]
package rgcd_pkg;

  // fixed header part: four budget bytes and the table size byte
  localparam int unsigned HeaderFixed   = 5;
  localparam int unsigned TableDepthDef = 256;
  localparam int unsigned OnesMax       = 15;

  typedef struct packed {
    logic [7:0] sym;
    logic       stream_end;
    logic       rank_err;
  } res_t;

  // budget still has bits left: positive as a signed word
  function automatic logic budget_pos(logic [31:0] b);
    budget_pos = !b[31] && (b != 32'd0);
  endfunction

endpackage

[rtl/core/rank_gamma_code_decoder.sv]
// rank table gamma code decoder
//
// s_axis: one stream byte per beat, tdata = data byte, tuser = first of
//   stream (restarts the decoder, the byte is then header byte zero).
// m_axis: one decoded symbol per beat, tdata = symbol, tlast = last symbol
//   caused by its input byte, tuser = {rank_error, stream_end}.
// header bytes (budget, table size, rank table) do not use the bit engine.
// a code byte can yield up to eight symbols; it runs one code bit per
//   cycle through the bit engine unless m_axis stalls, ending early
//   when the budget runs out. the rank table is a single port synchronous
//   memory, written by header bytes and read once per finished code.
// a symbol passes from stage 1 through a holding stage to the output
//   register; it waits in the holding stage until the next symbol
//   of the same byte or the end of that byte settles its tlast.
// after reset the decoder is idle and drops bytes until one with tuser set.
// rank table contents are not cleared by reset; a new header fills them.
// when m_axis stalls and stage 1 is held, the bit engine freezes and
//   s_axis_tready_o falls; no beat is lost.
module rank_gamma_code_decoder
  import rgcd_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tuser_i,   // [0] first_of_stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] symbol
  output logic       m_axis_tlast_o,   // last_of_run
  output logic [1:0] m_axis_tuser_o    // [0] stream_end, [1] rank_error
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // decoder state
  logic [8:0]  hdr_pos_q, hdr_pos_d;
  logic [31:0] budget_q, budget_d;
  logic [8:0]  tbl_size_q, tbl_size_d;
  logic [3:0]  ones_q, ones_d;
  logic        suffix_q, suffix_d;
  logic [7:0]  accum_q, accum_d;
  logic        ovf_q, ovf_d;
  logic        done_q, done_d;

  // bit engine
  logic        busy_q, busy_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [6:0]  shift_q, shift_d;

  // stage 1: finished code with its table read in flight
  logic        s1_occ_q, s1_occ_d;
  logic        s1_res_q, s1_res_d;
  logic        s1_fin_q, s1_fin_d;
  logic        s1_end_q, s1_end_d;
  logic        s1_err_q, s1_err_d;
  logic [7:0]  rd_q;

  // holding stage and output register
  logic        p_vld_q, p_vld_d;
  logic        p_fin_q, p_fin_d;
  res_t        p_res_q;
  logic        o_vld_q, o_vld_d;
  logic        o_last_q;
  res_t        o_res_q;

  logic [7:0]  tbl_mem [TABLE_DEPTH];

  logic        acc, fos, adv, o_free, need_out, send;
  logic [8:0]  hp_e, ts_e, hp_inc, wr_idx;
  logic [31:0] budget_e;
  logic        done_e, data_go, bit_v, bit_b, end_b, last_bit;
  logic        emit, ovf_e;
  logic [7:0]  rank;
  logic        err;
  logic        tbl_we;
  logic [9:0]  hdr_len;

  // ---------------------------------------------------------------------
  // output side: holding stage decides tlast, output register parts sides
  // ---------------------------------------------------------------------
  always_comb begin
    o_free   = !o_vld_q || m_axis_tready_i;
    need_out = p_vld_q && (p_fin_q || s1_res_q);
    adv      = !s1_occ_q || !need_out || o_free;
    send     = p_vld_q && o_free && (p_fin_q || (s1_occ_q && s1_res_q));

    p_vld_d = p_vld_q && !send;
    p_fin_d = p_fin_q;
    if (s1_occ_q && adv) begin
      if (s1_res_q) begin
        p_vld_d = 1'b1;
        p_fin_d = s1_fin_q;
      end else begin
        p_fin_d = p_fin_q | s1_fin_q;
      end
    end

    o_vld_d = send ? 1'b1 : (o_vld_q && !m_axis_tready_i);
  end

  assign s_axis_tready_o = !busy_q && adv;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign fos             = s_axis_tuser_i;

  // ---------------------------------------------------------------------
  // header parsing and bit engine
  // ---------------------------------------------------------------------
  always_comb begin
    hp_e     = fos ? '0 : hdr_pos_q;
    ts_e     = fos ? '0 : tbl_size_q;
    budget_e = fos ? '0 : budget_q;
    done_e   = fos ? 1'b0 : done_q;
    hp_inc   = hp_e + 9'd1;
    hdr_len  = 10'(HeaderFixed) + {1'b0, ts_e};
    wr_idx   = hp_e - 9'(HeaderFixed);

    hdr_pos_d  = hdr_pos_q;
    budget_d   = budget_q;
    tbl_size_d = tbl_size_q;
    ones_d     = ones_q;
    suffix_d   = suffix_q;
    accum_d    = accum_q;
    ovf_d      = ovf_q;
    done_d     = done_q;
    busy_d     = busy_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    tbl_we     = 1'b0;
    data_go    = 1'b0;

    if (acc) begin
      if (fos) begin
        hdr_pos_d  = '0;
        budget_d   = '0;
        tbl_size_d = '0;
        ones_d     = '0;
        suffix_d   = 1'b0;
        accum_d    = '0;
        ovf_d      = 1'b0;
        done_d     = 1'b0;
      end
      if (!done_e) begin
        if (hp_e < 9'(HeaderFixed)) begin
          // budget bytes little endian, then table size minus one
          if (hp_e[2]) begin
            tbl_size_d = {1'b0, s_axis_tdata_i} + 9'd1;
          end else begin
            budget_d = budget_e | ({24'd0, s_axis_tdata_i} << {hp_e[1:0], 3'b000});
          end
          hdr_pos_d = hp_inc;
        end else if ({1'b0, hp_e} < hdr_len) begin
          tbl_we    = wr_idx < 9'(TABLE_DEPTH);
          hdr_pos_d = hp_inc;
          if ({1'b0, hp_inc} == hdr_len && !budget_pos(budget_e)) begin
            done_d = 1'b1;
          end
        end else if (!budget_pos(budget_e)) begin
          done_d = 1'b1;
        end else begin
          data_go = 1'b1;
        end
      end
    end

    // one code bit, from the incoming byte or from the shift register
    bit_v    = busy_q ? adv : data_go;
    bit_b    = busy_q ? shift_q[0] : s_axis_tdata_i[0];
    end_b    = budget_q == 32'd1;
    last_bit = end_b || (busy_q && cnt_q == 3'd1);
    emit     = 1'b0;
    ovf_e    = 1'b0;
    rank     = '0;

    if (bit_v) begin
      if (suffix_q) begin
        accum_d = {accum_q[6:0], bit_b};
        ones_d  = ones_q - 4'd1;
        if (ones_q == 4'd1) begin
          suffix_d = 1'b0;
          emit     = 1'b1;
          rank     = {accum_q[6:0], bit_b};
          ovf_e    = ovf_q;
          ovf_d    = 1'b0;
        end
      end else if (bit_b) begin
        // run of ones saturates
        if (ones_q != 4'(OnesMax)) begin
          ones_d = ones_q + 4'd1;
        end
      end else if (ones_q == 4'd0) begin
        emit = 1'b1;
      end else begin
        accum_d = 8'd1;
        ones_d  = ones_q - 4'd1;
        if (ones_q != 4'd1) begin
          suffix_d = 1'b1;
          ovf_d    = (ones_q - 4'd1) >= 4'd8;
        end else begin
          emit = 1'b1;
          rank = 8'd1;
        end
      end

      budget_d = budget_q - 32'd1;
      if (end_b) begin
        done_d = 1'b1;
      end
      busy_d  = !last_bit;
      cnt_d   = busy_q ? cnt_q - 3'd1 : 3'd7;
      shift_d = busy_q ? {1'b0, shift_q[6:1]} : s_axis_tdata_i[7:1];
    end

    err = ovf_e || ({1'b0, rank} >= tbl_size_q) || ({1'b0, rank} >= 9'(TABLE_DEPTH));

    s1_occ_d = s1_occ_q;
    s1_res_d = s1_res_q;
    s1_fin_d = s1_fin_q;
    s1_end_d = s1_end_q;
    s1_err_d = s1_err_q;
    if (adv) begin
      s1_occ_d = bit_v && (emit || last_bit);
      s1_res_d = bit_v && emit;
      s1_fin_d = bit_v && last_bit;
      s1_end_d = end_b;
      s1_err_d = err;
    end
  end

  // rank table: written by header bytes, read when a code finishes
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[wr_idx[AW-1:0]] <= s_axis_tdata_i;
    end
    if (bit_v && emit) begin
      rd_q <= tbl_mem[rank[AW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    if (s1_occ_q && adv && s1_res_q) begin
      p_res_q.sym        <= s1_err_q ? 8'd0 : rd_q;
      p_res_q.stream_end <= s1_end_q;
      p_res_q.rank_err   <= s1_err_q;
    end
    if (send) begin
      o_res_q  <= p_res_q;
      o_last_q <= p_fin_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q  <= '0;
      budget_q   <= '0;
      tbl_size_q <= '0;
      ones_q     <= '0;
      suffix_q   <= 1'b0;
      accum_q    <= '0;
      ovf_q      <= 1'b0;
      done_q     <= 1'b1;
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      s1_occ_q   <= 1'b0;
      s1_res_q   <= 1'b0;
      s1_fin_q   <= 1'b0;
      s1_end_q   <= 1'b0;
      s1_err_q   <= 1'b0;
      p_vld_q    <= 1'b0;
      p_fin_q    <= 1'b0;
      o_vld_q    <= 1'b0;
    end else begin
      hdr_pos_q  <= hdr_pos_d;
      budget_q   <= budget_d;
      tbl_size_q <= tbl_size_d;
      ones_q     <= ones_d;
      suffix_q   <= suffix_d;
      accum_q    <= accum_d;
      ovf_q      <= ovf_d;
      done_q     <= done_d;
      busy_q     <= busy_d;
      cnt_q      <= cnt_d;
      s1_occ_q   <= s1_occ_d;
      s1_res_q   <= s1_res_d;
      s1_fin_q   <= s1_fin_d;
      s1_end_q   <= s1_end_d;
      s1_err_q   <= s1_err_d;
      p_vld_q    <= p_vld_d;
      p_fin_q    <= p_fin_d;
      o_vld_q    <= o_vld_d;
    end
  end

  assign m_axis_tvalid_o = o_vld_q;
  assign m_axis_tdata_o  = o_res_q.sym;
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tuser_o  = {o_res_q.rank_err, o_res_q.stream_end};

endmodule

[rtl/core/rgcd_checker.sv]
module rgcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic [1:0] m_axis_tuser_o
);

  // stalled beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output beat dropped while stalled");

  // stalled beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("output payload changed while stalled");

  // bad rank gives a zero symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tdata_o == 8'd0)
    else $error("rank error with nonzero symbol");

  // budget end closes the byte's run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tlast_o)
    else $error("stream end without tlast");

endmodule

bind rank_gamma_code_decoder rgcd_checker u_rgcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
